// ===== src/gfa_pkg.sv =====
// Shared types, constants and codes for the binary field arithmetic unit.
package gfa_pkg;

  localparam int FD_W           = 6;
  localparam int POLY_W         = 64;
  localparam int APB_DW         = 64;
  localparam int APB_AW         = 4;
  localparam int MAX_DEGREE_DEF = 63;

  localparam logic [POLY_W-1:0] POLY_RESET   = 64'h8000_0000_0000_0003;
  localparam logic [FD_W-1:0]   DEGREE_RESET = 6'd63;
  localparam logic [FD_W-1:0]   DEGREE_MIN   = 6'd2;

  // Register index, taken from address bit 3.
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_DEG  = 1'b1;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_INV = 2'd3;

  typedef struct packed {
    logic [POLY_W-1:0] poly;
    logic [FD_W-1:0]   degree;
  } cfg_t;

endpackage

// ===== src/gfa_cfg.sv =====
// Configuration register file with APB-style access and degree clamping.
module gfa_cfg #(
  parameter int MAX_DEGREE = gfa_pkg::MAX_DEGREE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfa_pkg::APB_AW-1:0]  paddr,
  input  logic [gfa_pkg::APB_DW-1:0]  pwdata,
  output logic [gfa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output gfa_pkg::cfg_t               cfg_o
);
  import gfa_pkg::*;

  logic [POLY_W-1:0] poly_r;
  logic [FD_W-1:0]   fdeg_r;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
      fdeg_r <= DEGREE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POLY: poly_r <= pwdata[POLY_W-1:0];
        REG_DEG:  fdeg_r <= pwdata[FD_W-1:0];
        default:  poly_r <= poly_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEG: prdata = {{(APB_DW-FD_W){1'b0}}, fdeg_r};
      default: prdata = poly_r;
    endcase
  end

  // Out-of-range degrees are pulled into the supported span.
  always_comb begin
    cfg_o.poly = poly_r;
    if (fdeg_r < DEGREE_MIN) begin
      cfg_o.degree = DEGREE_MIN;
    end else if (fdeg_r > FD_W'(MAX_DEGREE)) begin
      cfg_o.degree = FD_W'(MAX_DEGREE);
    end else begin
      cfg_o.degree = fdeg_r;
    end
  end

endmodule

// ===== src/gfa_degree.sv =====
// Registered leading-one locator that returns the bit length of a word.
module gfa_degree #(
  parameter int W  = 64,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic [W-1:0]  word_i,
  output logic [DW-1:0] deg_o
);
  localparam int NG = (W + 7) / 8;

  logic [NG*8-1:0] padded;
  logic [NG-1:0]   nz_r;
  logic [2:0]      pos_r [NG];
  logic [NG-1:0]   nz_nxt;
  logic [2:0]      pos_nxt [NG];

  assign padded = {{(NG*8-W){1'b0}}, word_i};

  // First stage: per-byte nonzero flag and local top-bit position.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      nz_nxt[g]  = |padded[g*8 +: 8];
      pos_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (padded[g*8+b]) pos_nxt[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    nz_r <= nz_nxt;
    for (int g = 0; g < NG; g++) begin
      pos_r[g] <= pos_nxt[g];
    end
  end

  // Second stage: the highest nonzero byte decides the length.
  always_comb begin
    deg_o = '0;
    for (int g = 0; g < NG; g++) begin
      if (nz_r[g]) deg_o = DW'(g * 8) + DW'(pos_r[g]) + DW'(1);
    end
  end

endmodule

// ===== src/gfa_core.sv =====
// Sequencer and shift-XOR datapaths for add, multiply and inverse.
module gfa_core #(
  parameter int MAX_DEGREE = gfa_pkg::MAX_DEGREE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gfa_pkg::cfg_t          cfg_i,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [MAX_DEGREE-1:0]  in_operand_a,
  input  logic [MAX_DEGREE-1:0]  in_operand_b,
  output logic                   done_o,
  input  logic                   take_i,
  output logic [MAX_DEGREE-1:0]  result_o,
  output logic                   error_o
);
  import gfa_pkg::*;

  localparam int E          = MAX_DEGREE;
  localparam int W          = E + 1;
  localparam int DW         = $clog2(W + 1);
  localparam int SW         = $clog2(2 * E + 5);
  localparam int STEP_LIMIT = 2 * E + 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_VDEG = 3'd2;
  localparam logic [2:0] S_VCAP = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_UDEG = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [E-1:0]  a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [W-1:0]  u_r, u_nxt, v_r, v_nxt;
  logic [E-1:0]  g1_r, g1_nxt, g2_r, g2_nxt;
  logic [DW-1:0] du_r, du_nxt, dv_r, dv_nxt;
  logic [FD_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [E-1:0]  res_r, res_nxt;
  logic          err_r, err_nxt;

  logic [E-1:0]  mask, top_bit, red, a_in, b_in, b_shift;
  logic [W-1:0]  fmask;
  logic [W-1:0]  scan_word;
  logic [DW-1:0] deg;
  logic          swap;
  logic [DW-1:0] shamt;
  logic [W-1:0]  uu, vv;
  logic [E-1:0]  gg1, gg2;

  always_comb begin
    for (int i = 0; i < E; i++) begin
      mask[i] = (i < int'(cfg_i.degree));
    end
    for (int i = 0; i < W; i++) begin
      fmask[i] = (i <= int'(cfg_i.degree));
    end
  end

  assign top_bit = mask & ~(mask >> 1);
  assign red     = cfg_i.poly[E-1:0] & mask;
  assign a_in    = in_operand_a & mask;
  assign b_in    = in_operand_b & mask;
  assign b_shift = (b_r << 1) & mask;

  assign scan_word = (state_r == S_VDEG) ? v_r : u_r;

  gfa_degree #(
    .W  (W),
    .DW (DW)
  ) u_degree (
    .clk    (clk),
    .word_i (scan_word),
    .deg_o  (deg)
  );

  // One Euclid update: align the shorter of u and v under the leading bit of the longer and cancel it.
  assign swap  = du_r < dv_r;
  assign shamt = swap ? (dv_r - du_r) : (du_r - dv_r);
  assign uu    = swap ? v_r  : u_r;
  assign vv    = swap ? u_r  : v_r;
  assign gg1   = swap ? g2_r : g1_r;
  assign gg2   = swap ? g1_r : g2_r;

  assign in_ready = (state_r == S_IDLE);
  assign done_o   = (state_r == S_DONE);
  assign result_o = res_r;
  assign error_o  = err_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    g1_nxt    = g1_r;
    g2_nxt    = g2_r;
    du_nxt    = du_r;
    dv_nxt    = dv_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt = 1'b0;
          case (in_func)
            FUNC_ADD, FUNC_SUB: begin
              res_nxt   = a_in ^ b_in;
              state_nxt = S_DONE;
            end
            FUNC_MUL: begin
              a_nxt     = a_in;
              b_nxt     = b_in;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_MUL;
            end
            default: begin
              if (a_in == '0) begin
                res_nxt   = '0;
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                u_nxt     = {1'b0, a_in};
                v_nxt     = cfg_i.poly[W-1:0] & fmask;
                g1_nxt    = E'(1);
                g2_nxt    = '0;
                steps_nxt = '0;
                state_nxt = S_VDEG;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = a_r[0] ? (acc_r ^ b_r) : acc_r;
        a_nxt   = a_r >> 1;
        b_nxt   = (|(b_r & top_bit)) ? (b_shift ^ red) : b_shift;
        cnt_nxt = cnt_r + FD_W'(1);
        if (cnt_r == cfg_i.degree - FD_W'(1)) begin
          res_nxt   = acc_nxt;
          state_nxt = S_DONE;
        end
      end
      S_VDEG: begin
        state_nxt = S_VCAP;
      end
      S_VCAP: begin
        dv_nxt    = deg;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (u_r == W'(1)) begin
          res_nxt   = g1_r & mask;
          state_nxt = S_DONE;
        end else if (u_r == '0 || v_r == '0 || steps_r >= SW'(STEP_LIMIT)) begin
          res_nxt   = '0;
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          steps_nxt = steps_r + SW'(1);
          state_nxt = S_UDEG;
        end
      end
      S_UDEG: begin
        du_nxt    = deg;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        u_nxt     = uu ^ (vv << shamt);
        g1_nxt    = gg1 ^ (gg2 << shamt);
        v_nxt     = vv;
        g2_nxt    = gg2;
        dv_nxt    = swap ? du_r : dv_r;
        state_nxt = S_CHK;
      end
      S_DONE: begin
        if (take_i) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    g1_r    <= g1_nxt;
    g2_r    <= g2_nxt;
    du_r    <= du_nxt;
    dv_r    <= dv_nxt;
    cnt_r   <= cnt_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
    err_r   <= err_nxt;
  end

endmodule

// ===== src/binary_field_arithmetic_unit.sv =====
// Top level of the GF(2^m) polynomial-basis arithmetic unit.
// This block adds, subtracts, multiplies and inverts elements of GF(2^m) in
// polynomial basis, with the reduction polynomial and the degree m set
// through the APB-style register port (polynomial at byte address 0, degree
// at byte address 8; a degree below 2 acts as 2 and one above MAX_DEGREE acts
// as MAX_DEGREE). Operand bits at or above m are ignored. The unit works on
// one request at a time and drops in_ready until that request has finished
// its work and moved to the output register. Add and subtract go straight
// to the done state. Multiply runs one shift-and-reduce step per cycle over
// the m bits of operand_a. Inverse runs the binary extended Euclid loop on a
// shift-XOR datapath with a single shared leading-one locator; after a setup
// that finds the bit length of v, every Euclid step does a termination
// check, a bit-length search for u in the leading-one locator and a shifted
// update, for at most 2 * MAX_DEGREE + 4 steps. Inverting zero, or a failed
// inversion under a reducible polynomial, returns zero with out_error set. A
// finished result sits in the output register until it is taken, and a new
// request is taken as soon as the previous one has moved there.
// Configuration may only be written while the unit holds no request.
module binary_field_arithmetic_unit #(
  parameter int MAX_DEGREE = gfa_pkg::MAX_DEGREE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [MAX_DEGREE-1:0]       in_operand_a,
  input  logic [MAX_DEGREE-1:0]       in_operand_b,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [MAX_DEGREE-1:0]       out_result,
  output logic                        out_error,
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gfa_pkg::APB_AW-1:0]  paddr,
  input  logic [gfa_pkg::APB_DW-1:0]  pwdata,
  output logic [gfa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gfa_pkg::*;

  cfg_t                  cfg;
  logic                  core_done;
  logic                  core_take;
  logic [MAX_DEGREE-1:0] core_result;
  logic                  core_error;

  logic                  out_valid_r, out_valid_nxt;
  logic [MAX_DEGREE-1:0] out_result_r;
  logic                  out_error_r;

  gfa_cfg #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gfa_core #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .done_o       (core_done),
    .take_i       (core_take),
    .result_o     (core_result),
    .error_o      (core_error)
  );

  // The finished result moves into the output register whenever that
  // register is empty or is being emptied in the same cycle, which frees the
  // core for the next request while the consumer may still be stalling.
  assign core_take = core_done && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      out_result_r <= core_result;
      out_error_r  <= core_error;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule
